### rtl/bqed_pkg.sv
// Shared types, constants and the quadrature transition table for the
// button and quadrature event decoder. No dependencies.
package bqed_pkg;

    // Number of encoders wired to the encoder port (pin pairs 2e, 2e+1)
    localparam int NUM_ENCODERS = 4;

    localparam int PIN_W   = 8;
    localparam int PHASE_W = 4;
    localparam int ENC_SLOTS = PIN_W / 2;

    // Detent markers in the transition table
    localparam logic [7:0] DETENT_A   = 8'hF0;
    localparam logic [7:0] DETENT_B   = 8'h0F;
    localparam logic [3:0] PHASE_MASK = 4'hF;
    localparam logic [7:0] PAIR_MASK  = 8'h03;

    // Port selector carried in tuser
    localparam logic CMD_BUTTON  = 1'b0;
    localparam logic CMD_ENCODER = 1'b1;

    typedef struct packed {
        logic [PIN_W-1:0]                    button_expect;
        logic [PIN_W-1:0]                    encoder_expect;
        logic [ENC_SLOTS-1:0][PHASE_W-1:0]   encoder_phase;
    } t_state;

    typedef struct packed {
        logic [PIN_W-1:0] encoder_level_mask;
        logic [PIN_W-1:0] button_level_mask;
        logic [PIN_W-1:0] rotation_event;
        logic [PIN_W-1:0] button_event;
    } t_result;

    // Quadrature transition table: row is the current phase, column the
    // Gray-coded input pair; rows without an entry read as an invalid move.
    function automatic logic [7:0] step_next(input logic [3:0] row, input logic [1:0] col);
        logic [7:0] nxt;
        nxt = 8'h00;
        case ({row, col})
            {4'd0,  2'd1}: nxt = 8'h01;
            {4'd0,  2'd2}: nxt = 8'h08;
            {4'd1,  2'd1}: nxt = 8'h01;
            {4'd1,  2'd3}: nxt = 8'h03;
            {4'd2,  2'd0}: nxt = DETENT_B;
            {4'd2,  2'd2}: nxt = 8'h02;
            {4'd2,  2'd3}: nxt = 8'h03;
            {4'd3,  2'd1}: nxt = 8'h01;
            {4'd3,  2'd2}: nxt = 8'h02;
            {4'd3,  2'd3}: nxt = 8'h03;
            {4'd4,  2'd0}: nxt = DETENT_A;
            {4'd4,  2'd1}: nxt = 8'h04;
            {4'd4,  2'd3}: nxt = 8'h0C;
            {4'd8,  2'd2}: nxt = 8'h08;
            {4'd8,  2'd3}: nxt = 8'h0C;
            {4'd12, 2'd1}: nxt = 8'h04;
            {4'd12, 2'd2}: nxt = 8'h08;
            {4'd12, 2'd3}: nxt = 8'h0C;
            default:       nxt = 8'h00;
        endcase
        return nxt;
    endfunction

endpackage

### rtl/button_and_quadrature_event_decoder.sv
// Top level of the button and quadrature event decoder: input register,
// decoder state, result register. Depends on bqed_pkg and bqed_step.
//
// Usage:
//   Slave channel (i_s_*) takes one debounced event word per handshake:
//   tdata is the active pin set, tuser selects the port (0 buttons,
//   1 encoders). Empty or multi-pin sets change nothing.
//   Master channel (o_m_*) gives exactly one result word per event:
//   button_event, rotation_event, button_level_mask, encoder_level_mask.
//   A word passes from the input handshake through the input register,
//   then through the decode logic into the result register. Throughput
//   is one word per cycle while the receiver takes each result, set by
//   the combinational table lookup and mask update between the registers.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more word; then o_s_tready drops until
//   the result is taken.
//   Synchronous active-low reset empties both registers, sets both
//   expected-level masks to all ones and clears all encoder phases.
module button_and_quadrature_event_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] active_pins
    input  logic [0:0]  i_s_tuser,   // [0] cmd
    // result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [7:0] button_event, [15:8] rotation_event,
                                     // [23:16] button_level_mask,
                                     // [31:24] encoder_level_mask
);

    logic                          r_in_valid;
    logic                          r_cmd;
    logic [bqed_pkg::PIN_W-1:0]    r_pins;
    bqed_pkg::t_state              r_state;
    bqed_pkg::t_state              n_state;
    bqed_pkg::t_result             r_res;
    bqed_pkg::t_result             n_res;
    logic                          r_out_valid;
    logic                          fire;
    logic                          in_take;

    // Advance a word when the result register is free or being drained
    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;
    assign in_take    = i_s_tvalid && o_s_tready;

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd  <= i_s_tuser[0];
            r_pins <= i_s_tdata;
        end
    end

    bqed_step u_step (
        .i_state  (r_state),
        .i_cmd    (r_cmd),
        .i_pins   (r_pins),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // Commit decoder state with each advanced word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.button_expect  <= '1;
            r_state.encoder_expect <= '1;
            r_state.encoder_phase  <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_res;

`ifndef ASSERT_OFF
    // A single word never reports both a press and a detent
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.button_event == '0 || r_res.rotation_event == '0))
        else $error("button and rotation event in one word");

    // Events name a single pin
    a_event_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($onehot0(r_res.button_event) && $onehot0(r_res.rotation_event)))
        else $error("event is not one-hot");

    // Encoder phases only reach defined table rows
    a_phase_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.encoder_phase[0] < 4'd13) && (r_state.encoder_phase[1] < 4'd13)
        && (r_state.encoder_phase[2] < 4'd13) && (r_state.encoder_phase[3] < 4'd13))
        else $error("encoder phase outside table");

    // A stalled result word stays put
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_res)))
        else $error("result word changed under stall");
`endif

endmodule

### rtl/bqed_step.sv
// Next-state and result logic for one event word of the decoder.
// Depends on bqed_pkg (state/result types, transition table).
module bqed_step (
    input  bqed_pkg::t_state             i_state,
    input  logic                         i_cmd,
    input  logic [bqed_pkg::PIN_W-1:0]   i_pins,
    output bqed_pkg::t_state             o_state,
    output bqed_pkg::t_result            o_result
);

    logic                         pin_valid;
    logic [2:0]                   pin_idx;
    logic [1:0]                   enc;
    logic                         enc_present;
    logic [bqed_pkg::PHASE_W-1:0] last;
    logic [1:0]                   col_base;
    logic [1:0]                   col;
    logic [7:0]                   nxt;
    logic [bqed_pkg::PIN_W-1:0]   pair;
    logic                         reset_move;

    // Accept only a single active pin
    assign pin_valid = (i_pins != '0) && ((i_pins & (i_pins - 8'd1)) == '0);

    // Encode the one-hot pin to its index
    always_comb begin
        pin_idx = '0;
        for (int i = 0; i < bqed_pkg::PIN_W; i++) begin
            if (i_pins[i]) begin
                pin_idx = pin_idx | 3'(i);
            end
        end
    end

    assign enc         = pin_idx[2:1];
    assign enc_present = ({1'b0, enc} < 3'(bqed_pkg::NUM_ENCODERS));
    assign last        = i_state.encoder_phase[enc] & bqed_pkg::PHASE_MASK;
    assign col_base    = (last > 4'd3) ? last[3:2] : last[1:0];
    assign col         = col_base ^ (pin_idx[0] ? 2'b10 : 2'b01);
    assign nxt         = bqed_pkg::step_next(last, col);
    assign pair        = bqed_pkg::PAIR_MASK << {enc, 1'b0};
    assign reset_move  = (nxt == 8'h00) || (nxt == bqed_pkg::DETENT_A)
                      || (nxt == bqed_pkg::DETENT_B);

    // Update the addressed button bit or encoder nibble
    always_comb begin
        o_state                 = i_state;
        o_result.button_event   = '0;
        o_result.rotation_event = '0;
        if (pin_valid) begin
            if (i_cmd == bqed_pkg::CMD_BUTTON) begin
                if ((i_state.button_expect & i_pins) != '0) begin
                    o_state.button_expect = i_state.button_expect & ~i_pins;
                end else begin
                    o_state.button_expect = i_state.button_expect | i_pins;
                    o_result.button_event = i_pins;
                end
            end else if (enc_present) begin
                if (reset_move) begin
                    o_state.encoder_phase[enc] = '0;
                    o_state.encoder_expect     = i_state.encoder_expect | pair;
                    if (nxt != 8'h00) begin
                        o_result.rotation_event = i_pins;
                    end
                end else begin
                    o_state.encoder_phase[enc] = nxt[3:0];
                    o_state.encoder_expect     = i_state.encoder_expect ^ i_pins;
                end
            end
        end
        o_result.button_level_mask  = o_state.button_expect;
        o_result.encoder_level_mask = o_state.encoder_expect;
    end

endmodule
